/* hw/rtl/gsr_pkg.sv */
// ----------------------------------------------------------------------------
// gsr_pkg
// Shared types and constants for the scatter reduce gradient accumulator.
// ----------------------------------------------------------------------------
package gsr_pkg;

  localparam int DEF_NUM_ROWS   = 1024;
  localparam int DEF_FEAT_WIDTH = 64;

  localparam logic [1:0] MODE_SUM    = 2'd0;
  localparam logic [1:0] MODE_MEAN   = 2'd1;
  localparam logic [1:0] MODE_MINMAX = 2'd2;

  localparam logic KIND_ACC  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [9:0]         row;
    logic [5:0]         column;
    logic signed [31:0] grad_value;
    logic [15:0]        edge_count;
    logic signed [31:0] forward_out_value;
    logic signed [31:0] forward_in_value;
  } gsr_in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               divide_fault;
  } gsr_out_t;

endpackage

/* hw/rtl/gsr_ram.sv */
// ----------------------------------------------------------------------------
// gsr_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/gsr_div.sv */
// ----------------------------------------------------------------------------
// gsr_div
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module gsr_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic [15:0]        divisor,
  output logic               done,
  output logic [31:0]        quotient
);

  logic        busy;
  logic [4:0]  cnt;
  logic [16:0] rem;
  logic [31:0] quo;
  logic [15:0] dvs;
  logic        neg;
  logic [16:0] shifted;
  logic        fits;

  assign shifted  = {rem[15:0], quo[31]};
  assign fits     = shifted >= {1'b0, dvs};
  assign quotient = neg ? (~quo + 32'd1) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      // magnitude of the most negative value still fits unsigned
      quo <= dividend[31] ? (~dividend + 32'd1) : dividend;
      dvs <= divisor;
      neg <= dividend[31];
    end else if (busy) begin
      rem <= fits ? (shifted - {1'b0, dvs}) : shifted;
      quo <= {quo[30:0], fits};
    end
  end

endmodule

/* hw/rtl/graph_scatter_reduce_grad_unit.sv */
// ----------------------------------------------------------------------------
// graph_scatter_reduce_grad_unit
// Gradient store for the backward pass of a graph scatter reduce.
//
//   channel   signals                    role
//   in        in_valid/in_ready/in_data  accumulate or read-and-clear item
//   out       out_valid/out_ready/out_data  result of a read item
//   cfg       cfg_we/cfg_data            reduce_mode register write
//
// An item passes through accept, memory read, then modify and write back.
// An in-range mean accumulate with nonzero count also waits on the serial divider.
// After reset a clearing pass writes zero to all NUM_ROWS*FEAT_WIDTH entries,
// one per cycle (65536 entries by default); no item is accepted meanwhile.
// A read item waits in the write-back cycle while the output register is full.
// ----------------------------------------------------------------------------
module graph_scatter_reduce_grad_unit
  import gsr_pkg::*;
#(
  parameter int NUM_ROWS   = DEF_NUM_ROWS,
  parameter int FEAT_WIDTH = DEF_FEAT_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  gsr_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output gsr_out_t   out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_data
);

  localparam int DEPTH = NUM_ROWS * FEAT_WIDTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_MOD   = 3'd4;

  logic [2:0]    state;
  logic [1:0]    reduce_mode;
  logic          fault_flag;
  gsr_in_t       item;
  logic          in_range;
  logic [AW-1:0] addr;
  logic [AW-1:0] clr_addr;

  logic          in_xfer;
  logic          in_data_range;
  logic          slot_free;
  logic          out_push;
  logic          div_start;
  logic          div_done;
  logic [31:0]   div_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [31:0]   ram_rdata;

  logic          add;
  logic [31:0]   delta;

  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign in_data_range = (32'(in_data.row) < 32'(NUM_ROWS)) &&
                         (32'(in_data.column) < 32'(FEAT_WIDTH));
  assign slot_free = !out_valid || out_ready;
  assign out_push  = (state == S_MOD) && (item.kind == KIND_READ) && slot_free;
  assign div_start = in_xfer && (in_data.kind == KIND_ACC) &&
                     (reduce_mode == MODE_MEAN) && in_data_range &&
                     (in_data.edge_count != 16'd0);

  gsr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (in_data.grad_value),
    .divisor  (in_data.edge_count),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    add   = 1'b0;
    delta = item.grad_value;
    case (reduce_mode)
      MODE_SUM:    add = 1'b1;
      MODE_MEAN: begin
        add   = (item.edge_count != 16'd0);
        delta = div_q;
      end
      MODE_MINMAX: add = (item.forward_out_value == item.forward_in_value);
      default:     add = 1'b0;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
    end else if (state == S_MOD && in_range) begin
      if (item.kind == KIND_READ) begin
        ram_we = slot_free;
      end else begin
        ram_we    = add;
        ram_wdata = ram_rdata + delta;
      end
    end
  end

  gsr_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (state == S_RD),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      reduce_mode <= MODE_SUM;
      fault_flag  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        reduce_mode <= cfg_data;
      end
      if (out_push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            state <= div_start ? S_DIV : S_RD;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_RD;
          end
        end
        S_RD: state <= S_MOD;
        S_MOD: begin
          if (item.kind == KIND_READ) begin
            if (slot_free) begin
              fault_flag <= 1'b0;
              state      <= S_IDLE;
            end
          end else begin
            if (in_range && reduce_mode == MODE_MEAN && item.edge_count == 16'd0) begin
              fault_flag <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item     <= in_data;
      in_range <= in_data_range;
      addr     <= AW'(in_data.row) * AW'(FEAT_WIDTH) + AW'(in_data.column);
    end
    if (out_push) begin
      out_data.read_value   <= in_range ? ram_rdata : 32'd0;
      out_data.divide_fault <= fault_flag;
    end
  end

  // a result appears only from the write-back of a read item
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_MOD && item.kind == KIND_READ))
    else $error("result without read item");

  // the divider finishes only while the sequencer waits on it
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider done outside wait");

  // store is written only by the clearing pass or write-back
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_MOD))
    else $error("unexpected store write");

  // fault flag is clear right after a read transfer completes
  assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD && item.kind == KIND_READ && slot_free) |=> !fault_flag)
    else $error("fault not cleared by read");

endmodule

/* tb/graph_scatter_reduce_grad_unit_test.sv */
// ----------------------------------------------------------------------------
// graph_scatter_reduce_grad_unit_test
// Drives accumulate and read-and-clear items through the gradient store
// under each reduce mode, predicts every read result with a local copy of
// the store and fault bit, and compares results in order.
// ----------------------------------------------------------------------------
module graph_scatter_reduce_grad_unit_test;
  import gsr_pkg::*;

  localparam int N_ROWS = DEF_NUM_ROWS;
  localparam int N_COLS = DEF_FEAT_WIDTH;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int N_DIRECTED = 20;
  // mode code with no defined behavior, accumulates add nothing
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  gsr_in_t in_data;
  logic out_valid;
  logic out_ready;
  gsr_out_t out_data;
  logic cfg_we;
  logic [1:0] cfg_data;

  graph_scatter_reduce_grad_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // predictor state
  logic [31:0] grad_copy [N_ROWS*N_COLS];
  logic fault_copy;
  logic [1:0] mode_copy;
  gsr_out_t pending_reads [$];

  int errors = 0;
  int cycles = 0;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void predict_item(gsr_in_t it);
    int idx;
    logic [31:0] delta;
    gsr_out_t res;
    idx = int'(it.row) * N_COLS + int'(it.column);
    if (it.kind == KIND_READ) begin
      res.read_value = grad_copy[idx];
      res.divide_fault = fault_copy;
      grad_copy[idx] = '0;
      fault_copy = 1'b0;
      pending_reads.push_back(res);
    end else begin
      case (mode_copy)
        MODE_SUM: grad_copy[idx] = grad_copy[idx] + it.grad_value;
        MODE_MEAN: begin
          if (it.edge_count == 16'd0) begin
            fault_copy = 1'b1;
          end else begin
            delta = 32'(longint'(it.grad_value) / longint'(it.edge_count));
            grad_copy[idx] = grad_copy[idx] + delta;
          end
        end
        MODE_MINMAX: begin
          if (it.forward_out_value == it.forward_in_value)
            grad_copy[idx] = grad_copy[idx] + it.grad_value;
        end
        default: ;
      endcase
    end
  endfunction

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    gsr_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_reads.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected read result %h", out_data);
      end else begin
        want = pending_reads.pop_front();
        if (want.read_value !== out_data.read_value ||
            want.divide_fault !== out_data.divide_fault) begin
          errors++;
          if (errors <= 10)
            $display("read mismatch: expected %h/%b got %h/%b",
                     want.read_value, want.divide_fault,
                     out_data.read_value, out_data.divide_fault);
        end
      end
    end
  end

  // valid stays up after a transfer until the next idle cycle or drain
  task automatic send_item(gsr_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(it);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    // mean accumulates carry no result and may still be in the divider
    repeat (60) @(posedge clk);
  endtask

  task automatic write_mode(logic [1:0] m);
    drain_results();
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_copy = m;
  endtask

  function automatic gsr_in_t make_item(logic k, int r, int c, logic [31:0] g,
                                        logic [15:0] n, logic [31:0] fo,
                                        logic [31:0] fi);
    gsr_in_t it;
    it.kind = k;
    it.row = 10'(r);
    it.column = 6'(c);
    it.grad_value = g;
    it.edge_count = n;
    it.forward_out_value = fo;
    it.forward_in_value = fi;
    return it;
  endfunction

  // small hot region so reads usually find accumulated values
  function automatic gsr_in_t random_item(int read_pct);
    gsr_in_t it;
    int r;
    int c;
    logic [31:0] fi;
    if ($urandom_range(9) == 0) begin
      r = $urandom_range(N_ROWS - 1);
      c = $urandom_range(N_COLS - 1);
    end else begin
      r = $urandom_range(3) * 341;
      c = $urandom_range(3) * 21;
    end
    fi = $urandom;
    it = make_item(($urandom_range(99) < read_pct) ? KIND_READ : KIND_ACC, r, c,
                   $urandom, 16'($urandom_range(4) == 0 ? $urandom_range(3) : $urandom),
                   $urandom_range(1) ? fi : 32'($urandom), fi);
    return it;
  endfunction

  typedef struct {
    logic [1:0] mode;
    gsr_in_t item;
    bit known;
    gsr_out_t result;
  } directed_row_t;

  directed_row_t directed [N_DIRECTED];

  initial begin
    directed[0]  = '{MODE_SUM, make_item(KIND_READ, 0, 0, 0, 0, 0, 0), 1, '{32'd0, 1'b0}};
    directed[1]  = '{MODE_SUM, make_item(KIND_READ, 1023, 63, 0, 0, 0, 0), 1, '{32'd0, 1'b0}};
    directed[2]  = '{MODE_SUM, make_item(KIND_ACC, 1023, 63, 32'h7fffffff, 0, 0, 1), 0, '{0, 0}};
    directed[3]  = '{MODE_SUM, make_item(KIND_ACC, 1023, 63, 32'd1, 16'hffff, 1, 2), 0, '{0, 0}};
    directed[4]  = '{MODE_SUM, make_item(KIND_READ, 1023, 63, 0, 0, 0, 0), 1,
                     '{32'h80000000, 1'b0}};
    directed[5]  = '{MODE_MEAN, make_item(KIND_ACC, 5, 7, 32'hfffffff9, 16'd2, 0, 0), 0, '{0, 0}};
    directed[6]  = '{MODE_MEAN, make_item(KIND_ACC, 5, 7, 32'h80000000, 16'hffff, 0, 0), 0, '{0, 0}};
    directed[7]  = '{MODE_MEAN, make_item(KIND_ACC, 5, 7, 32'd100, 16'd0, 0, 0), 0, '{0, 0}};
    directed[8]  = '{MODE_MEAN, make_item(KIND_READ, 5, 7, 0, 0, 0, 0), 0, '{0, 0}};
    directed[9]  = '{MODE_MEAN, make_item(KIND_READ, 5, 7, 0, 0, 0, 0), 1, '{32'd0, 1'b0}};
    directed[10] = '{MODE_MEAN, make_item(KIND_ACC, 0, 0, 32'h7fffffff, 16'd1, 0, 0), 0, '{0, 0}};
    directed[11] = '{MODE_MEAN, make_item(KIND_READ, 0, 0, 0, 0, 0, 0), 1,
                     '{32'h7fffffff, 1'b0}};
    directed[12] = '{MODE_MINMAX, make_item(KIND_ACC, 9, 1, 32'd40, 0, 32'h80000000,
                     32'h80000000), 0, '{0, 0}};
    directed[13] = '{MODE_MINMAX, make_item(KIND_ACC, 9, 1, 32'd3, 0, 32'h7fffffff,
                     32'h80000000), 0, '{0, 0}};
    directed[14] = '{MODE_MINMAX, make_item(KIND_READ, 9, 1, 0, 0, 0, 0), 1, '{32'd40, 1'b0}};
    directed[15] = '{MODE_UNUSED, make_item(KIND_ACC, 2, 2, 32'd77, 16'd0, 0, 0), 0, '{0, 0}};
    directed[16] = '{MODE_UNUSED, make_item(KIND_READ, 2, 2, 0, 0, 0, 0), 1, '{32'd0, 1'b0}};
    directed[17] = '{MODE_SUM, make_item(KIND_ACC, 512, 32, 32'hffffffff, 16'hffff,
                     32'hffffffff, 32'hffffffff), 0, '{0, 0}};
    directed[18] = '{MODE_SUM, make_item(KIND_ACC, 512, 32, 32'hffffffff, 0, 0, 0), 0, '{0, 0}};
    directed[19] = '{MODE_SUM, make_item(KIND_READ, 512, 32, 0, 0, 0, 0), 1, '{32'hfffffffe, 1'b0}};
  end

  initial begin
    logic [1:0] modes [4];
    int pct [4][2];
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_data = MODE_SUM;
    fault_copy = 1'b0;
    mode_copy = MODE_SUM;
    for (int i = 0; i < N_ROWS * N_COLS; i++) grad_copy[i] = '0;
    modes = '{MODE_SUM, MODE_MEAN, MODE_MINMAX, MODE_UNUSED};
    pct = '{'{0, 0}, '{63, 0}, '{0, 63}, '{6, 6}};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed table, run without idling
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed[i].mode != mode_copy) write_mode(directed[i].mode);
      if (directed[i].known) begin
        drain_results();
        send_item(directed[i].item);
        if (pending_reads[$] != directed[i].result) begin
          errors++;
          if (errors <= 10) $display("directed row %0d: table and prediction differ", i);
        end
      end else begin
        send_item(directed[i].item);
      end
    end

    // random: each idling phase under each mode
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = pct[p][0];
      recv_stall_pct = pct[p][1];
      for (int m = 0; m < 4; m++) begin
        write_mode(modes[(m + p) % 4]);
        for (int k = 0; k < 82; k++) send_item(random_item(30));
      end
    end

    // long receiver hold-off while reads keep arriving
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_mode(MODE_SUM);
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 20; k++) send_item(random_item(100));
    join
    // sender pauses until all results are back, then resumes
    drain_results();
    for (int k = 0; k < 10; k++) send_item(random_item(40));

    drain_results();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/gsr_pkg.sv
hw/rtl/gsr_ram.sv
hw/rtl/gsr_div.sv
hw/rtl/graph_scatter_reduce_grad_unit.sv
tb/graph_scatter_reduce_grad_unit_test.sv
